// ===== rtl/core/e2c_pkg.sv =====
package e2c_pkg;

  localparam int NumStages = 6;

  localparam logic [31:0] Offset2000   = 32'd946684800;
  localparam logic [31:0] SecPerDay    = 32'd86400;
  localparam logic [25:0] DayRecip     = 26'd50903317;
  localparam int          DayShift     = 35;
  localparam logic [15:0] DaysPerGroup = 16'd1461;
  localparam logic [16:0] GroupRecip   = 17'd91868;
  localparam int          GroupShift   = 27;
  localparam logic [17:0] MinRecip     = 18'd139811;
  localparam int          MinShift     = 23;
  localparam logic [11:0] HourRecip    = 12'd2185;
  localparam int          HourShift    = 17;

  localparam logic [10:0] MonthStart [4][12] = '{
    '{11'd0,    11'd31,   11'd60,   11'd91,   11'd121,  11'd152,
      11'd182,  11'd213,  11'd244,  11'd274,  11'd305,  11'd335},
    '{11'd366,  11'd397,  11'd425,  11'd456,  11'd486,  11'd517,
      11'd547,  11'd578,  11'd609,  11'd639,  11'd670,  11'd700},
    '{11'd731,  11'd762,  11'd790,  11'd821,  11'd851,  11'd882,
      11'd912,  11'd943,  11'd974,  11'd1004, 11'd1035, 11'd1065},
    '{11'd1096, 11'd1127, 11'd1155, 11'd1186, 11'd1216, 11'd1247,
      11'd1277, 11'd1308, 11'd1339, 11'd1369, 11'd1400, 11'd1430}
  };

  typedef struct packed {
    logic [NumStages-1:0] en;
  } ctrl_t;

endpackage

// ===== rtl/core/e2c_ctrl.sv =====
module e2c_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           stall_o,
  output logic           valid_o,
  input  logic           stall_i,
  output e2c_pkg::ctrl_t ctrl_o
);

  localparam int N = e2c_pkg::NumStages;

  logic [N-1:0] v_q, v_d;
  logic [N-1:0] ready;

  always_comb begin
    ready[N-1] = !v_q[N-1] || !stall_i;
    for (int k = N - 2; k >= 0; k--) begin
      ready[k] = !v_q[k] || ready[k+1];
    end
  end

  always_comb begin
    v_d = v_q;
    if (ready[0]) begin
      v_d[0] = valid_i;
    end
    for (int k = 1; k < N; k++) begin
      if (ready[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign ctrl_o.en = ready;
  assign stall_o   = !ready[0];
  assign valid_o   = v_q[N-1];

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> v_q[0])
    else $error("accepted transaction did not enter the pipeline");

  a_stall_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (&v_q))
    else $error("input stalled with a bubble in the pipeline");

  a_stall_needs_back : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stall_i |-> !stall_o)
    else $error("input stalled while output is free");

endmodule

// ===== rtl/core/e2c_tod.sv =====
module e2c_tod (
  input  logic           clk_i,
  input  e2c_pkg::ctrl_t ctrl_i,
  input  logic [31:0]    secs_i,
  input  logic [15:0]    days_i,
  output logic [4:0]     hour_o,
  output logic [5:0]     minute_o,
  output logic [5:0]     second_o
);

  logic [16:0] sod3_q, sod4_q;
  logic [10:0] mt4_q, mt5_q;
  logic [5:0]  sec5_q, sec6_q;
  logic [4:0]  hr5_q, hr6_q;
  logic [5:0]  min6_q;

  logic [31:0] sod_full;
  logic [34:0] mt_prod;
  logic [16:0] sec_full;
  logic [22:0] hr_prod;
  logic [10:0] min_full;

  assign sod_full = secs_i - ({16'b0, days_i} * e2c_pkg::SecPerDay);
  assign mt_prod  = {18'b0, sod3_q} * {17'b0, e2c_pkg::MinRecip};
  assign sec_full = sod4_q - ({6'b0, mt4_q} * 17'd60);
  assign hr_prod  = {12'b0, mt4_q} * {11'b0, e2c_pkg::HourRecip};
  assign min_full = mt5_q - ({6'b0, hr5_q} * 11'd60);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[2]) begin
      sod3_q <= sod_full[16:0];
    end
    if (ctrl_i.en[3]) begin
      sod4_q <= sod3_q;
      mt4_q  <= mt_prod[e2c_pkg::MinShift +: 11];
    end
    if (ctrl_i.en[4]) begin
      sec5_q <= sec_full[5:0];
      hr5_q  <= hr_prod[e2c_pkg::HourShift +: 5];
      mt5_q  <= mt4_q;
    end
    if (ctrl_i.en[5]) begin
      sec6_q <= sec5_q;
      hr6_q  <= hr5_q;
      min6_q <= min_full[5:0];
    end
  end

  assign hour_o   = hr6_q;
  assign minute_o = min6_q;
  assign second_o = sec6_q;

endmodule

// ===== rtl/core/e2c_date.sv =====
module e2c_date (
  input  logic           clk_i,
  input  e2c_pkg::ctrl_t ctrl_i,
  input  logic [15:0]    days_i,
  output logic [7:0]     year_o,
  output logic [3:0]     month_o,
  output logic [4:0]     day_o
);

  logic [15:0] days3_q;
  logic [5:0]  grp3_q, grp4_q, grp5_q;
  logic [10:0] dig4_q, dig5_q;
  logic [1:0]  yr5_q;
  logic [3:0]  mo5_q;
  logic [10:0] start5_q;
  logic [7:0]  year6_q;
  logic [3:0]  month6_q;
  logic [4:0]  day6_q;

  logic [32:0] grp_prod;
  logic [15:0] dig_full;
  logic [1:0]  yr;
  logic [3:0]  mo;
  logic [10:0] day_full;
  logic [7:0]  year_full;

  assign grp_prod = {17'b0, days_i} * {16'b0, e2c_pkg::GroupRecip};
  assign dig_full = days3_q - ({10'b0, grp3_q} * e2c_pkg::DaysPerGroup);

  always_comb begin
    yr = 2'd0;
    for (int y = 1; y < 4; y++) begin
      if (dig4_q >= e2c_pkg::MonthStart[y][0]) begin
        yr = yr + 2'd1;
      end
    end
    mo = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (dig4_q >= e2c_pkg::MonthStart[yr][m]) begin
        mo = mo + 4'd1;
      end
    end
  end

  assign day_full  = dig5_q - start5_q + 11'd1;
  assign year_full = {grp5_q, 2'b00} + {6'b0, yr5_q};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[2]) begin
      days3_q <= days_i;
      grp3_q  <= grp_prod[e2c_pkg::GroupShift +: 6];
    end
    if (ctrl_i.en[3]) begin
      dig4_q <= dig_full[10:0];
      grp4_q <= grp3_q;
    end
    if (ctrl_i.en[4]) begin
      dig5_q   <= dig4_q;
      grp5_q   <= grp4_q;
      yr5_q    <= yr;
      mo5_q    <= mo;
      start5_q <= e2c_pkg::MonthStart[yr][mo];
    end
    if (ctrl_i.en[5]) begin
      year6_q  <= year_full;
      month6_q <= mo5_q + 4'd1;
      day6_q   <= day_full[4:0];
    end
  end

  assign year_o  = year6_q;
  assign month_o = month6_q;
  assign day_o   = day6_q;

endmodule

// ===== rtl/core/epoch_to_calendar_time.sv =====
// Converts a 32-bit Unix second count into calendar date and time of day,
// years counted from 2000 (every fourth year leap, no century rule; inputs
// before 2000 wrap into years up to 136). One transaction is taken every
// cycle while the input is not stalled; each result passes through
// registered stages that hold a chain of constant-reciprocal multiplies
// and remainder subtracts. A stall on the output backs up through the
// stages, and the input stalls only once every stage is full.
module epoch_to_calendar_time (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [31:0] epoch_seconds_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [7:0]  year_offset_o,
  output logic [3:0]  month_number_o,
  output logic [4:0]  day_of_month_o,
  output logic [4:0]  hour_of_day_o,
  output logic [5:0]  minute_of_hour_o,
  output logic [5:0]  second_of_minute_o
);

  e2c_pkg::ctrl_t ctrl;

  logic [31:0] t1_q, t2_q;
  logic [15:0] days2_q;
  logic [50:0] day_prod;

  e2c_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .stall_o (stall_o),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .ctrl_o  (ctrl)
  );

  assign day_prod = {26'b0, t1_q[31:7]} * {25'b0, e2c_pkg::DayRecip};

  always_ff @(posedge clk_i) begin
    if (ctrl.en[0]) begin
      t1_q <= epoch_seconds_i - e2c_pkg::Offset2000;
    end
    if (ctrl.en[1]) begin
      t2_q    <= t1_q;
      days2_q <= day_prod[e2c_pkg::DayShift +: 16];
    end
  end

  e2c_tod u_tod (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .secs_i   (t2_q),
    .days_i   (days2_q),
    .hour_o   (hour_of_day_o),
    .minute_o (minute_of_hour_o),
    .second_o (second_of_minute_o)
  );

  e2c_date u_date (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .days_i  (days2_q),
    .year_o  (year_offset_o),
    .month_o (month_number_o),
    .day_o   (day_of_month_o)
  );

  a_time_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (second_of_minute_o < 6'd60 && minute_of_hour_o < 6'd60 &&
                 hour_of_day_o < 5'd24))
    else $error("time of day out of range");

  a_date_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (month_number_o != 4'd0 && month_number_o <= 4'd12 &&
                 day_of_month_o != 5'd0 && year_offset_o <= 8'd139))
    else $error("calendar date out of range");

endmodule

// ===== verif/tb.sv =====
module tb;

  localparam logic [31:0] EpochOffset = 32'd946684800;
  localparam int unsigned DaysPerGroup = 1461;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned PhaseItems = 500;

  typedef struct packed {
    logic [7:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } calendar_t;

  typedef struct packed {
    logic [31:0] epoch;
    logic        typed;
    calendar_t   cal;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] epoch;
    calendar_t   cal;
  } pending_date_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] epoch_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic [4:0]  hour_out;
  logic [5:0]  minute_out;
  logic [5:0]  second_out;

  logic        hold_off = 1'b0;
  int unsigned stall_pct = 0;
  int unsigned idle_pct = 0;
  int unsigned accepted_epochs = 0;
  int unsigned cycles = 0;
  int unsigned errors = 0;

  pending_date_t pending_dates[$];

  stim_row_t directed [19] = '{
    '{32'd946684800,  1'b1, '{8'd0, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0}},
    '{32'd946771199,  1'b1, '{8'd0, 4'd1,  5'd1,  5'd23, 6'd59, 6'd59}},
    '{32'd951782400,  1'b1, '{8'd0, 4'd2,  5'd29, 5'd0,  6'd0,  6'd0}},
    '{32'd978220800,  1'b1, '{8'd0, 4'd12, 5'd31, 5'd0,  6'd0,  6'd0}},
    '{32'd978307200,  1'b1, '{8'd1, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0}},
    '{32'd0,          1'b0, '0},
    '{32'd1,          1'b0, '0},
    '{32'hFFFF_FFFF,  1'b0, '0},
    '{32'd946684799,  1'b0, '0},
    '{32'h7FFF_FFFF,  1'b0, '0},
    '{32'h8000_0000,  1'b0, '0},
    '{32'hAAAA_AAAA,  1'b0, '0},
    '{32'h5555_5555,  1'b0, '0},
    '{32'd1041379200, 1'b0, '0},
    '{32'd1072828800, 1'b0, '0},
    '{32'd1072915199, 1'b0, '0},
    '{32'd1072915200, 1'b0, '0},
    '{32'd4107542399, 1'b0, '0},
    '{32'd4107542400, 1'b0, '0}
  };

  epoch_to_calendar_time dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (in_valid),
    .stall_o            (in_stall),
    .epoch_seconds_i    (epoch_in),
    .valid_o            (out_valid),
    .stall_i            (out_stall),
    .year_offset_o      (year_out),
    .month_number_o     (month_out),
    .day_of_month_o     (day_out),
    .hour_of_day_o      (hour_out),
    .minute_of_hour_o   (minute_out),
    .second_of_minute_o (second_out)
  );

  always #4 clk_i = ~clk_i;

  function automatic int unsigned month_days(int unsigned m, bit leap);
    case (m)
      1:       return leap ? 29 : 28;
      3, 5, 8, 10: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic int unsigned group_day_start(int unsigned yr, int unsigned mo);
    int unsigned s;
    s = (yr == 0) ? 0 : 366 + 365 * (yr - 1);
    for (int unsigned i = 0; i < mo; i++) s += month_days(i, yr == 0);
    return s;
  endfunction

  function automatic calendar_t to_calendar(logic [31:0] epoch);
    logic [31:0] t;
    int unsigned grp;
    int unsigned d;
    int unsigned yr;
    int unsigned mo;
    calendar_t c;
    t = epoch - EpochOffset;
    c.second = 6'(t % 60);
    t = t / 60;
    c.minute = 6'(t % 60);
    t = t / 60;
    c.hour = 5'(t % 24);
    t = t / 24;
    grp = t / DaysPerGroup;
    d = t % DaysPerGroup;
    yr = 0;
    while (yr < 3 && d >= group_day_start(yr + 1, 0)) yr++;
    mo = 0;
    while (mo < 11 && d >= group_day_start(yr, mo + 1)) mo++;
    c.year = 8'(grp * 4 + yr);
    c.month = 4'(mo + 1);
    c.day = 5'(d - group_day_start(yr, mo) + 1);
    return c;
  endfunction

  function automatic logic [31:0] random_epoch();
    int unsigned pick;
    logic [31:0] day;
    pick = $urandom_range(0, 9);
    if (pick < 5) return $urandom;
    if (pick < 8) return EpochOffset + $urandom_range(0, 32'hFFFF_FFFF - EpochOffset);
    day = 32'($urandom_range(0, 25) * DaysPerGroup
              + group_day_start($urandom_range(0, 3), $urandom_range(0, 11)));
    return 32'(EpochOffset + day * 86400 + $urandom_range(0, 4) - 2);
  endfunction

  task automatic check_field(string name, logic [31:0] epoch, int unsigned want,
                             int unsigned got);
    if (want != got) begin
      $display("%0t: epoch %0d %s expected %0d actual %0d", $time, epoch, name, want, got);
      errors++;
    end
  endtask

  task automatic offer_epoch(logic [31:0] epoch, bit typed, calendar_t cal);
    pending_date_t p;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    epoch_in <= epoch;
    do @(posedge clk_i); while (in_stall);
    p.epoch = epoch;
    p.cal = typed ? cal : to_calendar(epoch);
    pending_dates.push_back(p);
    accepted_epochs++;
  endtask

  task automatic run_phase(int unsigned idle, int unsigned stall);
    idle_pct = idle;
    stall_pct <= stall;
    repeat (PhaseItems) offer_epoch(random_epoch(), 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin : receiver
    pending_date_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected transaction, actual %0d-%0d-%0d %0d:%0d:%0d", $time,
                 year_out, month_out, day_out, hour_out, minute_out, second_out);
        errors++;
      end else begin
        want = pending_dates.pop_front();
        check_field("year", want.epoch, want.cal.year, year_out);
        check_field("month", want.epoch, want.cal.month, month_out);
        check_field("day", want.epoch, want.cal.day, day_out);
        check_field("hour", want.epoch, want.cal.hour, hour_out);
        check_field("minute", want.epoch, want.cal.minute, minute_out);
        check_field("second", want.epoch, want.cal.second, second_out);
      end
    end
    out_stall <= hold_off || ($urandom_range(0, 99) < stall_pct);
  end

  initial begin : pressure
    wait (accepted_epochs >= 100);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed[i]) offer_epoch(directed[i].epoch, directed[i].typed, directed[i].cal);
    run_phase(0, 0);
    run_phase(51, 0);
    run_phase(0, 51);
    run_phase(17, 17);
    in_valid <= 1'b0;
    wait (pending_dates.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_dates.size() != 0) errors++;
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/e2c_pkg.sv
rtl/core/e2c_ctrl.sv
rtl/core/e2c_tod.sv
rtl/core/e2c_date.sv
rtl/core/epoch_to_calendar_time.sv
verif/tb.sv
